### rtl/bm3d_pkg.sv
// shared types and constants for the 3d binary morphology block
package bm3d_pkg;

  localparam int XW = 9;
  localparam int ZW = 11;
  localparam int PLW = 2 * XW;
  localparam int AW = 4;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_DEPTH  = 2'd3;

  localparam logic MODE_DILATE = 1'b0;
  localparam logic MODE_ERODE  = 1'b1;

  localparam logic REQ_VOXEL = 1'b0;
  localparam logic REQ_PAD   = 1'b1;

  typedef struct packed {
    logic          mode;
    logic [XW-1:0] width;
    logic [XW-1:0] height;
    logic [ZW-1:0] depth;
  } cfg_t;

endpackage

### rtl/bm3d_if.sv
// request and result channel interfaces
interface bm3d_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] voxel_in;
  modport source (output valid, req_type, voxel_in, input ready);
  modport sink (input valid, req_type, voxel_in, output ready);
endinterface

interface bm3d_out_if;
  logic valid;
  logic ready;
  logic voxel_out;
  logic volume_end;
  modport source (output valid, voxel_out, volume_end, input ready);
  modport sink (input valid, voxel_out, volume_end, output ready);
endinterface

### rtl/bm3d_regs.sv
// apb configuration registers
module bm3d_regs (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [bm3d_pkg::AW-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output bm3d_pkg::cfg_t        cfg
);
  import bm3d_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode   <= MODE_DILATE;
      cfg.width  <= XW'(256);
      cfg.height <= XW'(256);
      cfg.depth  <= ZW'(256);
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_MODE:   cfg.mode   <= pwdata[0];
        REG_WIDTH:  cfg.width  <= pwdata[XW-1:0];
        REG_HEIGHT: cfg.height <= pwdata[XW-1:0];
        REG_DEPTH:  cfg.depth  <= pwdata[ZW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:   prdata = {31'd0, cfg.mode};
      REG_WIDTH:  prdata = 32'(cfg.width);
      REG_HEIGHT: prdata = 32'(cfg.height);
      REG_DEPTH:  prdata = 32'(cfg.depth);
      default:    prdata = 32'd0;
    endcase
  end

endmodule

### rtl/bm3d_delay.sv
// circular delay memory with prefetched read, delay set by len
module bm3d_delay #(
  parameter int DEPTH = 256,
  parameter int DW = 2,
  parameter int LW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic          restart,
  input  logic [LW-1:0] len,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);
  localparam int PW = $clog2(DEPTH);

  logic [DW-1:0] mem [DEPTH];
  logic [PW-1:0] ptr;
  logic [PW-1:0] ptr_next;

  always_comb begin
    if (restart || (32'(ptr) == 32'(len) - 32'd1)) begin
      ptr_next = '0;
    end else begin
      ptr_next = ptr + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (step) begin
      ptr <= ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      mem[ptr] <= wdata;
    end
    rdata <= mem[step ? ptr_next : ptr];
  end

endmodule

### rtl/binary_morphology_3d.sv
// 3d binary dilation / erosion over a 26-neighbor window, streaming top level
// output: a result is registered and leaves in the cycle after the request that completes its window,
//   i.e. one plane plus one row plus one voxel of requests behind its own voxel
// throughput: one request per cycle; each delay memory writes one entry and prefetches the next
//   on every step, and a held result stalls requests until it is taken
// reset: synchronous, clears position counters and output valid; memories are not cleared
module binary_morphology_3d #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_DEPTH = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  bm3d_in_if.sink                 in_req,
  bm3d_out_if.source              out_res,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [bm3d_pkg::AW-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import bm3d_pkg::*;

  cfg_t cfg;
  logic [XW-1:0] cw, ch, lw, lh, ew, eh;
  logic [ZW-1:0] cd, ld, ed;
  logic lmode, emode, active, started;
  logic [PLW-1:0] plane;
  logic [XW-1:0] ix, iy, ox, oy;
  logic [ZW:0] iz;
  logic [ZW-1:0] oz;
  logic [8:0] col, col1, col2;
  logic [1:0] prd;
  logic [5:0] rrd;
  logic [2:0] a;
  logic acc, pad, in_vol, step, vbit, emit, last;
  logic xlo, xhi, ylo, yhi, zlo, zhi;
  logic res_any, res_all, res;

  bm3d_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  always_comb begin
    if (cfg.width < XW'(2)) cw = XW'(2);
    else if (32'(cfg.width) > MAX_WIDTH) cw = XW'(MAX_WIDTH);
    else cw = cfg.width;
    if (cfg.height < XW'(2)) ch = XW'(2);
    else if (32'(cfg.height) > MAX_HEIGHT) ch = XW'(MAX_HEIGHT);
    else ch = cfg.height;
    if (cfg.depth < ZW'(2)) cd = ZW'(2);
    else if (32'(cfg.depth) > MAX_DEPTH) cd = ZW'(MAX_DEPTH);
    else cd = cfg.depth;
  end

  assign ew = active ? lw : cw;
  assign eh = active ? lh : ch;
  assign ed = active ? ld : cd;
  assign emode = active ? lmode : cfg.mode;

  assign in_req.ready = !out_res.valid || out_res.ready;
  assign acc = in_req.valid && in_req.ready;
  assign pad = (in_req.req_type == REQ_PAD);
  assign in_vol = !active || (iz < {1'b0, ld});
  assign step = acc && !(pad && in_vol);
  assign vbit = in_vol && !pad && (in_req.voxel_in != 8'd0);

  assign emit = step && (started || (ix == XW'(1) && iy == XW'(1) && iz == (ZW+1)'(1)));
  assign last = (ox == ew - XW'(1)) && (oy == eh - XW'(1)) && (oz == ed - ZW'(1));

  bm3d_delay #(.DEPTH(MAX_WIDTH * MAX_HEIGHT), .DW(2), .LW(PLW)) u_plane (
    .clk, .rst, .step, .restart(emit && last), .len(plane),
    .wdata({prd[0], vbit}), .rdata(prd)
  );

  assign a = {prd[1], prd[0], vbit};

  bm3d_delay #(.DEPTH(MAX_WIDTH), .DW(6), .LW(XW)) u_row (
    .clk, .rst, .step, .restart(emit && last), .len(ew),
    .wdata({rrd[2:0], a}), .rdata(rrd)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      col[k*3]   = a[k];
      col[k*3+1] = rrd[k];
      col[k*3+2] = rrd[3+k];
    end
  end

  assign xlo = (ox != '0);
  assign xhi = (ox != ew - XW'(1));
  assign ylo = (oy != '0);
  assign yhi = (oy != eh - XW'(1));
  assign zlo = (oz != '0);
  assign zhi = (oz != ed - ZW'(1));

  always_comb begin
    logic b, ok;
    res_any = 1'b0;
    res_all = 1'b1;
    for (int dz = 0; dz < 3; dz++) begin
      for (int dy = 0; dy < 3; dy++) begin
        for (int dx = 0; dx < 3; dx++) begin
          unique case (dx)
            2: b = col[(2-dz)*3 + (2-dy)];
            1: b = col1[(2-dz)*3 + (2-dy)];
            default: b = col2[(2-dz)*3 + (2-dy)];
          endcase
          ok = (dx != 0 || xlo) && (dx != 2 || xhi) && (dy != 0 || ylo) &&
               (dy != 2 || yhi) && (dz != 0 || zlo) && (dz != 2 || zhi);
          res_any = res_any | (ok & b);
          res_all = res_all & b;
        end
      end
    end
    if (emode == MODE_ERODE) res = xlo && xhi && ylo && yhi && zlo && zhi && res_all;
    else res = res_any;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      started <= 1'b0;
      ix <= '0;
      iy <= '0;
      iz <= '0;
      ox <= '0;
      oy <= '0;
      oz <= '0;
      out_res.valid <= 1'b0;
    end else begin
      if (emit) begin
        out_res.valid <= 1'b1;
      end else if (out_res.ready) begin
        out_res.valid <= 1'b0;
      end
      if (step) begin
        if (emit && last) begin
          active <= 1'b0;
          started <= 1'b0;
          ix <= '0;
          iy <= '0;
          iz <= '0;
          ox <= '0;
          oy <= '0;
          oz <= '0;
        end else begin
          active <= 1'b1;
          if (emit) begin
            started <= 1'b1;
            if (ox == ew - XW'(1)) begin
              ox <= '0;
              if (oy == eh - XW'(1)) begin
                oy <= '0;
                oz <= oz + ZW'(1);
              end else begin
                oy <= oy + XW'(1);
              end
            end else begin
              ox <= ox + XW'(1);
            end
          end
          if (ix == ew - XW'(1)) begin
            ix <= '0;
            if (iy == eh - XW'(1)) begin
              iy <= '0;
              iz <= iz + (ZW+1)'(1);
            end else begin
              iy <= iy + XW'(1);
            end
          end else begin
            ix <= ix + XW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!active) begin
      lmode <= cfg.mode;
      lw <= cw;
      lh <= ch;
      ld <= cd;
      plane <= PLW'(cw) * PLW'(ch);
    end
    if (step) begin
      col1 <= col;
      col2 <= col1;
    end
    if (emit) begin
      out_res.voxel_out <= res;
      out_res.volume_end <= last;
    end
  end

endmodule

### tb/bm3d_checker.sv
// checker: predicts morphology results from observed requests and compares them
`timescale 1ns / 1ps
module bm3d_checker (
  input  logic                    clk,
  input  logic                    rst,
  bm3d_in_if                      in_req,
  bm3d_out_if                     out_res,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [bm3d_pkg::AW-1:0] paddr,
  input  logic [31:0]             pwdata,
  input  logic                    pready,
  output int                      errors,
  output int                      pending,
  output int                      results
);
  import bm3d_pkg::*;

  typedef struct packed {
    logic voxel_out;
    logic volume_end;
  } morph_res_t;

  morph_res_t  expected_voxels[$];
  cfg_t        regs;
  cfg_t        vol;
  int          in_pos;
  bit          history[int];

  function automatic int clampv(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic morph_voxel(int p);
    int w, h, d, x, y, z, nx, ny, nz;
    bit erode, v;
    w = int'(vol.width);
    h = int'(vol.height);
    d = int'(vol.depth);
    x = p % w;
    y = (p / w) % h;
    z = p / (w * h);
    erode = (vol.mode == MODE_ERODE);
    if (erode && (x == 0 || y == 0 || z == 0 || x == w - 1 || y == h - 1 || z == d - 1))
      return 1'b0;
    for (int dz = -1; dz <= 1; dz++)
      for (int dy = -1; dy <= 1; dy++)
        for (int dx = -1; dx <= 1; dx++) begin
          nx = x + dx;
          ny = y + dy;
          nz = z + dz;
          if (nx < 0 || ny < 0 || nz < 0 || nx >= w || ny >= h || nz >= d) continue;
          v = history.exists(nz * w * h + ny * w + nx) ? history[nz * w * h + ny * w + nx] : 1'b0;
          if (!erode && v) return 1'b1;
          if (erode && !v) return 1'b0;
        end
    return erode;
  endfunction

  task automatic take_request(logic rtype, logic [7:0] vin);
    int total, lag, q;
    morph_res_t r;
    if (in_pos == 0) begin
      if (rtype == REQ_PAD) return;
      vol.mode   = regs.mode;
      vol.width  = XW'(clampv(int'(regs.width), 2, 256));
      vol.height = XW'(clampv(int'(regs.height), 2, 256));
      vol.depth  = ZW'(clampv(int'(regs.depth), 2, 1024));
      history.delete();
    end
    total = int'(vol.width) * int'(vol.height) * int'(vol.depth);
    lag = int'(vol.width) * int'(vol.height) + int'(vol.width) + 1;
    if (in_pos < total) begin
      if (rtype == REQ_PAD) return;
      history[in_pos] = (vin != 8'd0);
    end
    q = in_pos;
    in_pos++;
    if (q < lag) return;
    r.voxel_out = morph_voxel(q - lag);
    r.volume_end = (q - lag == total - 1);
    if (r.volume_end) in_pos = 0;
    expected_voxels.push_back(r);
  endtask

  always @(posedge clk) begin
    morph_res_t e;
    if (rst) begin
      regs.mode = MODE_DILATE;
      regs.width = 9'd256;
      regs.height = 9'd256;
      regs.depth = 11'd256;
      in_pos = 0;
      expected_voxels.delete();
      errors = 0;
      results = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MODE:   regs.mode = pwdata[0];
          REG_WIDTH:  regs.width = pwdata[XW-1:0];
          REG_HEIGHT: regs.height = pwdata[XW-1:0];
          REG_DEPTH:  regs.depth = pwdata[ZW-1:0];
          default: ;
        endcase
      end
      if (out_res.valid && out_res.ready) begin
        results++;
        if (expected_voxels.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: unexpected result voxel_out=%0b volume_end=%0b",
                     out_res.voxel_out, out_res.volume_end);
        end else begin
          e = expected_voxels.pop_front();
          if (e.voxel_out !== out_res.voxel_out || e.volume_end !== out_res.volume_end) begin
            errors++;
            if (errors <= 10)
              $display("mismatch at result %0d: expected out=%0b end=%0b, got out=%0b end=%0b",
                       results, e.voxel_out, e.volume_end, out_res.voxel_out,
                       out_res.volume_end);
          end
        end
      end
      if (in_req.valid && in_req.ready) take_request(in_req.req_type, in_req.voxel_in);
    end
    pending = expected_voxels.size();
  end
endmodule

### tb/tb.sv
// testbench top: stimulus, idling phases and verdict for the 3d morphology block
`timescale 1ns / 1ps
module tb;
  import bm3d_pkg::*;

  localparam int WATCHDOG = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int errors, pending, results;
  int idle_pct = 0, stall_pct = 0;
  int sent = 0, volumes = 0, quiet = 0, hold_cnt = 0;
  bit long_hold = 1'b0;

  bm3d_in_if in_req ();
  bm3d_out_if out_res ();

  binary_morphology_3d i_dut (
    .clk, .rst, .in_req, .out_res, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  bm3d_checker i_checker (
    .clk, .rst, .in_req, .out_res, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .pending, .results
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (long_hold && hold_cnt < 400) begin
      out_res.ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_res.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_request(logic rtype, logic [7:0] vin);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.req_type <= rtype;
    in_req.voxel_in <= vin;
    do @(posedge clk); while (!in_req.ready);
    sent++;
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AW'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain;
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_voxel(int density);
    if ($urandom_range(0, 99) >= density) return 8'd0;
    case ($urandom_range(0, 3))
      0: return 8'd1;
      1: return 8'hff;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic int clampv(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic run_volume(logic mode, int w, int h, int d, int density, bit noisy);
    int cw, ch, cd, total, lag;
    drain();
    reg_write(REG_MODE, {31'd0, mode});
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_DEPTH, d);
    cw = clampv(w, 2, 256);
    ch = clampv(h, 2, 256);
    cd = clampv(d, 2, 1024);
    total = cw * ch * cd;
    lag = cw * ch + cw + 1;
    if (noisy && $urandom_range(0, 1)) send_request(REQ_PAD, 8'($urandom));
    for (int i = 0; i < total; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) send_request(REQ_PAD, 8'($urandom));
      send_request(REQ_VOXEL, pick_voxel(density));
    end
    for (int i = 0; i < lag; i++)
      send_request((noisy && $urandom_range(0, 9) == 0) ? REQ_VOXEL : REQ_PAD, 8'($urandom));
    volumes++;
  endtask

  task automatic random_volumes(int goal);
    logic mode;
    while (sent < goal) begin
      mode = $urandom_range(0, 1);
      run_volume(mode, $urandom_range(2, 6), $urandom_range(2, 6), $urandom_range(2, 5),
                 mode == MODE_ERODE ? $urandom_range(85, 100) : $urandom_range(0, 30),
                 $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    in_req.valid <= 1'b0;
    in_req.req_type <= REQ_VOXEL;
    in_req.voxel_in <= 8'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: smallest volume both ways, extreme voxel bytes
    drain();
    reg_write(REG_WIDTH, 2);
    reg_write(REG_HEIGHT, 2);
    reg_write(REG_DEPTH, 2);
    send_request(REQ_PAD, 8'hff);
    send_request(REQ_VOXEL, 8'h00);
    send_request(REQ_VOXEL, 8'h00);
    send_request(REQ_VOXEL, 8'h00);
    send_request(REQ_VOXEL, 8'h00);
    send_request(REQ_VOXEL, 8'h00);
    send_request(REQ_VOXEL, 8'h00);
    send_request(REQ_VOXEL, 8'h01);
    send_request(REQ_VOXEL, 8'h00);
    for (int i = 0; i < 7; i++) send_request(i == 3 ? REQ_VOXEL : REQ_PAD, 8'hff);
    run_volume(MODE_ERODE, 2, 2, 2, 100, 1'b0);
    run_volume(MODE_ERODE, 3, 3, 3, 100, 1'b0);

    idle_pct = 0;
    stall_pct = 0;
    random_volumes(300);

    idle_pct = 48;
    stall_pct = 0;
    random_volumes(550);

    idle_pct = 0;
    stall_pct = 48;
    drain();
    long_hold = 1'b1;
    random_volumes(800);

    idle_pct = 24;
    stall_pct = 24;
    random_volumes(1100);

    // long rows and columns, register values below the minimum
    idle_pct = 0;
    stall_pct = 10;
    run_volume(MODE_DILATE, 40, 1, 0, 3, 1'b1);
    run_volume(MODE_ERODE, 0, 0, 1, 100, 1'b0);
    run_volume(MODE_ERODE, 1, 40, 2, 100, 1'b1);

    drain();
    $display("covered %0d volumes, %0d requests, %0d results checked", volumes, sent, results);
    $display("dilate and erode, sizes 2 to 40, idle and stall phases");
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
